[hdl/hcc_pkg.sv]
package hcc_pkg;

    // Field widths.
    localparam int ANGLE_W   = 12;
    localparam int CURRENT_W = 16;
    localparam int DUTY_W    = 16;
    localparam int CMD_W     = 20;
    localparam int GAIN_W    = 16;
    localparam int INTEG_W   = 17;
    localparam int PERR_W    = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Profile geometry.
    localparam int PROFILE_LENGTH = 4000;
    localparam int EDGE_LENGTH    = 100;
    localparam int PROFILE_MAX    = 255;
    localparam int RAMP_SPAN      = PROFILE_LENGTH - 2 * EDGE_LENGTH;

    // Angle thresholds.
    localparam logic [ANGLE_W-1:0] ANGLE_MIN   = ANGLE_W'(20);
    localparam logic [ANGLE_W-1:0] ANGLE_MAX   = ANGLE_W'(PROFILE_LENGTH - 1);
    localparam logic [ANGLE_W-1:0] ANGLE_FLIP  = ANGLE_W'(3900);
    localparam logic [ANGLE_W-1:0] BRAKE_HIGH  = ANGLE_W'(3900);
    localparam logic [ANGLE_W-1:0] BRAKE_LOW   = ANGLE_W'(20);
    localparam logic [ANGLE_W-1:0] EDGE_LOW    = ANGLE_W'(EDGE_LENGTH);
    localparam logic [ANGLE_W-1:0] EDGE_HIGH   = ANGLE_W'(PROFILE_LENGTH - EDGE_LENGTH);

    // Reciprocal for the ramp division: ceil(2^32 / span), exact for numerators below 2^20.
    localparam int RAMP_SHIFT = 32;
    localparam logic [31:0] RAMP_RECIP =
        32'(((64'd1 << RAMP_SHIFT) + 64'(RAMP_SPAN) - 64'd1) / 64'(RAMP_SPAN));

    // Reciprocal for the current sensor scale of three, exact for numerators below 2^24.
    localparam int CUR_DIV   = 3;
    localparam int CUR_SHIFT = 26;
    localparam logic [24:0] CUR_RECIP = 25'(((1 << CUR_SHIFT) + CUR_DIV - 1) / CUR_DIV);

    // Output saturation bounds.
    localparam int CMD_MAX  = (1 << (CMD_W - 1)) - 1;
    localparam int CMD_MIN  = -(1 << (CMD_W - 1));
    localparam int DUTY_MAX = (1 << (DUTY_W - 1)) - 1;
    localparam int DUTY_MIN = -(1 << (DUTY_W - 1));

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_P_GAIN = 3'd0,
        CFG_CURRENT_I_GAIN = 3'd1,
        CFG_PROFILE_P_GAIN = 3'd2,
        CFG_PROFILE_D_GAIN = 3'd3,
        CFG_LOOP_ENABLE    = 3'd4,
        CFG_INTEGRAL_LIMIT = 3'd5,
        CFG_DUTY_LIMIT     = 3'd6
    } cfg_index_t;

    // Configuration reset values.
    localparam logic [GAIN_W-1:0] RST_CURRENT_P_GAIN = 16'd4;
    localparam logic [GAIN_W-1:0] RST_CURRENT_I_GAIN = 16'd1280;
    localparam logic [GAIN_W-1:0] RST_PROFILE_P_GAIN = 16'd205;
    localparam logic [GAIN_W-1:0] RST_PROFILE_D_GAIN = 16'd0;
    localparam logic [CFG_W-1:0]  RST_INTEGRAL_LIMIT = 16'd51200;
    localparam logic [CFG_W-1:0]  RST_DUTY_LIMIT     = 16'd25600;

endpackage

[hdl/cascaded_haptic_current_controller_unit.sv]
// Cascaded haptic current controller. Each input request carries one control tick (encoder
// angle and raw current-sensor word) and yields exactly one result request with the motor
// duty, the brake flag and the outer-loop current command. The block is an eight-stage
// pipeline that accepts one tick per clock cycle while the result side does not stall;
// each stage holds at most one multiplier level or one add-and-clamp, and the feedback state
// (previous angle, previous error, command and integrator) closes within a single stage.
// Backpressure on the result side stalls the pipeline stage by stage, so empty stages still
// fill while a finished result waits. Configuration must be written through the plain
// write port only while no tick is in flight; the block itself does not enforce this.
module cascaded_haptic_current_controller_unit
    import hcc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Input tick channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [31:0]          s_tdata,   // angle_raw[11:0], current_raw[27:12], zero fill
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [39:0]          m_tdata    // duty_percent[15:0], brake_request[16],
                                            // current_command[36:17], zero fill
);

    // Configuration registers.
    logic [GAIN_W-1:0] current_p_gain_reg, current_i_gain_reg;
    logic [GAIN_W-1:0] profile_p_gain_reg, profile_d_gain_reg;
    logic              loop_enable_reg;
    logic [CFG_W-1:0]  integral_limit_reg, duty_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            current_p_gain_reg <= RST_CURRENT_P_GAIN;
            current_i_gain_reg <= RST_CURRENT_I_GAIN;
            profile_p_gain_reg <= RST_PROFILE_P_GAIN;
            profile_d_gain_reg <= RST_PROFILE_D_GAIN;
            loop_enable_reg    <= 1'b0;
            integral_limit_reg <= RST_INTEGRAL_LIMIT;
            duty_limit_reg     <= RST_DUTY_LIMIT;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CURRENT_P_GAIN: current_p_gain_reg <= cfg_wdata;
                CFG_CURRENT_I_GAIN: current_i_gain_reg <= cfg_wdata;
                CFG_PROFILE_P_GAIN: profile_p_gain_reg <= cfg_wdata;
                CFG_PROFILE_D_GAIN: profile_d_gain_reg <= cfg_wdata;
                CFG_LOOP_ENABLE:    loop_enable_reg    <= cfg_wdata[0];
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_wdata;
                CFG_DUTY_LIMIT:     duty_limit_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage takes a new request when it is empty or its
    // occupant moves on in the same cycle.
    logic [8:1] vld_reg;
    logic [8:1] rdy;
    logic [8:1] ld;

    always_comb begin
        rdy[8] = !vld_reg[8] || m_tready;
        for (int k = 7; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        ld[1] = s_tvalid && rdy[1];
        for (int k = 2; k <= 8; k++) begin
            ld[k] = vld_reg[k-1] && rdy[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= 8; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_tready = rdy[1];
    assign m_tvalid = vld_reg[8];

    // Stage 1: input register.
    logic [ANGLE_W-1:0]          s1_angle_reg;
    logic signed [CURRENT_W-1:0] s1_current_reg;

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            s1_angle_reg   <= s_tdata[11:0];
            s1_current_reg <= $signed(s_tdata[27:12]);
        end
    end

    // Angle clamp, profile zones, ramp division and current scaling by reciprocal.
    logic [ANGLE_W-1:0]   angle_clamp;
    logic                 zone_low, zone_high;
    logic [ANGLE_W-1:0]   ramp_index;
    logic [19:0]          ramp_num;
    logic [51:0]          ramp_prod;
    logic                 cur_neg;
    logic [CURRENT_W-1:0] cur_abs;
    logic [23:0]          cur_num;
    logic [48:0]          cur_prod;

    always_comb begin
        priority if (s1_angle_reg > ANGLE_MAX) begin
            angle_clamp = ANGLE_MAX;
        end else if (s1_angle_reg < ANGLE_MIN) begin
            angle_clamp = ANGLE_MIN;
        end else begin
            angle_clamp = s1_angle_reg;
        end
        zone_low   = angle_clamp < EDGE_LOW;
        zone_high  = angle_clamp >= EDGE_HIGH;
        ramp_index = (zone_low || zone_high) ? '0 : angle_clamp - EDGE_LOW;
        // Multiply by 255 as a shift and subtract.
        ramp_num   = {ramp_index, 8'd0} - {8'd0, ramp_index};
        ramp_prod  = 52'(ramp_num) * 52'(RAMP_RECIP);
        cur_neg    = s1_current_reg[CURRENT_W-1];
        cur_abs    = cur_neg ? CURRENT_W'(-s1_current_reg) : CURRENT_W'(s1_current_reg);
        cur_num    = {cur_abs, 8'd0};
        cur_prod   = 49'(cur_num) * 49'(CUR_RECIP);
    end

    // Stage 2.
    logic [ANGLE_W-1:0] s2_angle_reg;
    logic               s2_low_reg, s2_high_reg, s2_flip_reg, s2_brake_reg, s2_neg_reg;
    logic [21:0]        s2_cur_mag_reg;
    logic [7:0]         s2_ramp_reg;

    always_ff @(posedge aclk) begin
        if (ld[2]) begin
            s2_angle_reg   <= angle_clamp;
            s2_low_reg     <= zone_low;
            s2_high_reg    <= zone_high;
            s2_flip_reg    <= angle_clamp > ANGLE_FLIP;
            s2_brake_reg   <= (s1_angle_reg > BRAKE_HIGH) || (s1_angle_reg < BRAKE_LOW);
            s2_neg_reg     <= cur_neg;
            s2_cur_mag_reg <= cur_prod[CUR_SHIFT +: 22];
            s2_ramp_reg    <= ramp_prod[RAMP_SHIFT +: 8];
        end
    end

    // Signed current and profile choice by direction of motion.
    logic [ANGLE_W-1:0] prev_angle_reg;
    logic signed [22:0] cur_pos, cur_q8;
    logic signed [8:0]  profile;

    always_comb begin
        cur_pos = $signed({1'b0, s2_cur_mag_reg});
        cur_q8  = s2_neg_reg ? -cur_pos : cur_pos;
        priority if (s2_low_reg) begin
            profile = -9'sd255;
        end else if (s2_high_reg) begin
            profile = 9'(PROFILE_MAX);
        end else if (s2_angle_reg > prev_angle_reg) begin
            profile = $signed({1'b0, s2_ramp_reg});
        end else begin
            profile = '0;
        end
    end

    // Stage 3; the previous angle advances with each tick.
    logic signed [8:0]  s3_profile_reg;
    logic signed [22:0] s3_cur_reg;
    logic               s3_flip_reg, s3_brake_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_angle_reg <= '0;
        end else if (ld[3]) begin
            prev_angle_reg <= s2_angle_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[3]) begin
            s3_profile_reg <= profile;
            s3_cur_reg     <= cur_q8;
            s3_flip_reg    <= s2_flip_reg;
            s3_brake_reg   <= s2_brake_reg;
        end
    end

    // Outer error, its change, and the integer part kept for the next tick.
    logic signed [PERR_W-1:0] prev_err_reg;
    logic signed [16:0]       prof_q8;
    logic signed [23:0]       perr_q8;
    logic signed [23:0]       err, err_bias, err_int;
    logic signed [24:0]       derr;

    always_comb begin
        prof_q8  = $signed({s3_profile_reg, 8'd0});
        perr_q8  = $signed({prev_err_reg, 8'd0});
        err      = 24'(prof_q8) - 24'(s3_cur_reg);
        derr     = 25'(err) - 25'(perr_q8);
        // Cut toward zero: bias negative values before the arithmetic shift.
        err_bias = err + $signed({16'd0, {8{err[23]}}});
        err_int  = err_bias >>> 8;
    end

    // Stage 4.
    logic signed [23:0] s4_err_reg, s4_cur_reg;
    logic signed [24:0] s4_derr_reg;
    logic               s4_flip_reg, s4_brake_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
        end else if (ld[4]) begin
            prev_err_reg <= err_int[PERR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[4]) begin
            s4_err_reg   <= err;
            s4_derr_reg  <= derr;
            s4_cur_reg   <= 24'(s3_cur_reg);
            s4_flip_reg  <= s3_flip_reg;
            s4_brake_reg <= s3_brake_reg;
        end
    end

    // PD gain products.
    logic signed [40:0] pd_p_prod;
    logic signed [41:0] pd_d_prod;

    always_comb begin
        pd_p_prod = $signed({1'b0, profile_p_gain_reg}) * s4_err_reg;
        pd_d_prod = $signed({1'b0, profile_d_gain_reg}) * s4_derr_reg;
    end

    // Stage 5.
    logic signed [40:0] s5_p_prod_reg;
    logic signed [41:0] s5_d_prod_reg;
    logic signed [23:0] s5_cur_reg;
    logic               s5_flip_reg, s5_brake_reg;

    always_ff @(posedge aclk) begin
        if (ld[5]) begin
            s5_p_prod_reg <= pd_p_prod;
            s5_d_prod_reg <= pd_d_prod;
            s5_cur_reg    <= s4_cur_reg;
            s5_flip_reg   <= s4_flip_reg;
            s5_brake_reg  <= s4_brake_reg;
        end
    end

    // Outer command (floor scale, flip, saturate) and the integrator update, which
    // acts on the command left by the previous tick.
    logic signed [CMD_W-1:0]   command_reg;
    logic signed [INTEG_W-1:0] integrator_reg;
    logic signed [42:0]        pd_sum, pd_shift;
    logic signed [31:0]        pd_ext, pd_signed;
    logic signed [CMD_W-1:0]   cmd_next;
    logic signed [23:0]        ie;
    logic signed [24:0]        integ_sum;
    logic signed [17:0]        ilim_pos, ilim_neg;
    logic signed [INTEG_W-1:0] integ_next;

    always_comb begin
        pd_sum    = 43'(s5_p_prod_reg) + 43'(s5_d_prod_reg);
        pd_shift  = pd_sum >>> 12;
        pd_ext    = $signed(pd_shift[31:0]);
        pd_signed = s5_flip_reg ? -pd_ext : pd_ext;
        priority if (pd_signed > CMD_MAX) begin
            cmd_next = CMD_W'(CMD_MAX);
        end else if (pd_signed < CMD_MIN) begin
            cmd_next = CMD_W'(CMD_MIN);
        end else begin
            cmd_next = pd_signed[CMD_W-1:0];
        end

        ie        = 24'(command_reg) - s5_cur_reg;
        integ_sum = 25'(integrator_reg) + 25'(ie);
        ilim_pos  = $signed({2'b00, integral_limit_reg});
        ilim_neg  = -ilim_pos;
        priority if (integ_sum > 25'(ilim_pos)) begin
            integ_next = INTEG_W'(ilim_pos);
        end else if (integ_sum < 25'(ilim_neg)) begin
            integ_next = INTEG_W'(ilim_neg);
        end else begin
            integ_next = integ_sum[INTEG_W-1:0];
        end
    end

    // Stage 6; command and integrator state close here.
    logic signed [CMD_W-1:0]   s6_cmd_reg;
    logic signed [23:0]        s6_ie_reg;
    logic signed [INTEG_W-1:0] s6_integ_reg;
    logic                      s6_brake_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            command_reg    <= '0;
            integrator_reg <= '0;
        end else if (ld[6]) begin
            command_reg <= cmd_next;
            if (loop_enable_reg) begin
                integrator_reg <= integ_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[6]) begin
            s6_cmd_reg   <= cmd_next;
            s6_ie_reg    <= ie;
            s6_integ_reg <= integ_next;
            s6_brake_reg <= s5_brake_reg;
        end
    end

    // PI gain products.
    logic signed [40:0] pi_p_prod;
    logic signed [33:0] pi_i_prod;

    always_comb begin
        pi_p_prod = $signed({1'b0, current_p_gain_reg}) * s6_ie_reg;
        pi_i_prod = $signed({1'b0, current_i_gain_reg}) * s6_integ_reg;
    end

    // Stage 7.
    logic signed [40:0]      s7_p_prod_reg;
    logic signed [33:0]      s7_i_prod_reg;
    logic signed [CMD_W-1:0] s7_cmd_reg;
    logic                    s7_brake_reg;

    always_ff @(posedge aclk) begin
        if (ld[7]) begin
            s7_p_prod_reg <= pi_p_prod;
            s7_i_prod_reg <= pi_i_prod;
            s7_cmd_reg    <= s6_cmd_reg;
            s7_brake_reg  <= s6_brake_reg;
        end
    end

    // Duty: floor scale, clamp to the duty limit, then to the 16-bit range.
    // The output duty register doubles as the held duty while the loop is off.
    logic signed [DUTY_W-1:0] out_duty_reg;
    logic signed [41:0]       pi_sum, pi_shift;
    logic signed [29:0]       pi_scaled, duty_lim;
    logic signed [17:0]       dlim_pos, dlim_neg;
    logic signed [DUTY_W-1:0] duty_sat, duty_next;

    always_comb begin
        pi_sum    = 42'(s7_p_prod_reg) + 42'(s7_i_prod_reg);
        pi_shift  = pi_sum >>> 12;
        pi_scaled = $signed(pi_shift[29:0]);
        dlim_pos  = $signed({2'b00, duty_limit_reg});
        dlim_neg  = -dlim_pos;
        priority if (pi_scaled > 30'(dlim_pos)) begin
            duty_lim = 30'(dlim_pos);
        end else if (pi_scaled < 30'(dlim_neg)) begin
            duty_lim = 30'(dlim_neg);
        end else begin
            duty_lim = pi_scaled;
        end
        priority if (duty_lim > DUTY_MAX) begin
            duty_sat = DUTY_W'(DUTY_MAX);
        end else if (duty_lim < DUTY_MIN) begin
            duty_sat = DUTY_W'(DUTY_MIN);
        end else begin
            duty_sat = duty_lim[DUTY_W-1:0];
        end
        duty_next = loop_enable_reg ? duty_sat : out_duty_reg;
    end

    // Stage 8: result register.
    logic                    out_brake_reg;
    logic signed [CMD_W-1:0] out_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_duty_reg <= '0;
        end else if (ld[8]) begin
            out_duty_reg <= duty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[8]) begin
            out_brake_reg <= s7_brake_reg;
            out_cmd_reg   <= s7_cmd_reg;
        end
    end

    assign m_tdata = {3'd0, out_cmd_reg, out_brake_reg, out_duty_reg};

    // A full input side means the result register is holding a request.
    a_stall_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled while the result register is empty");

    // With the inner loop off the integrator must hold.
    a_integrator_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !loop_enable_reg |=> $stable(integrator_reg))
        else $error("integrator changed while the inner loop is disabled");

    // A delivered result is replaced by whatever stage 7 held.
    a_output_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> (m_tvalid == $past(vld_reg[7])))
        else $error("result register did not refill from stage 7");

    // The command state advances only with a tick leaving stage 5.
    a_command_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !ld[6] |=> $stable(command_reg))
        else $error("command register changed without a tick");

endmodule
